// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the splitter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/ors_pkg.sv =====
// ----------------------------------------------------------------------------
// ors_pkg
// Widths, status codes and shared types of the object request splitter.
// ----------------------------------------------------------------------------
package ors_pkg;

  localparam int OFFSET_W = 48;  // byte offset and object index
  localparam int LEN_W    = 32;  // lengths, offsets in object, buffer position
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W  = OFFSET_W + LEN_W;            // 80
  localparam int OUT_DATA_W = OFFSET_W + 3 * LEN_W;        // 144

  localparam logic [LEN_W-1:0] OBJECT_SIZE_RESET = 32'd4194304;

  localparam logic [STATUS_W-1:0] ST_CHUNK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_LEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, quotient and remainder valid
  } div_status_t;

endpackage

// ===== rtl/core/ors_div.sv =====
// ----------------------------------------------------------------------------
// ors_div
// Restoring radix-2 divider: 48-bit dividend by 32-bit divisor, one quotient
// bit per cycle through a single 33-bit compare/subtract.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ors_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ors_pkg::OFFSET_W-1:0]    dividend,
  input  logic [ors_pkg::LEN_W-1:0]       divisor,
  output ors_pkg::div_status_t            status,
  output logic [ors_pkg::OFFSET_W-1:0]    quotient,
  output logic [ors_pkg::LEN_W-1:0]       remainder
);
  import ors_pkg::*;

  localparam int CNT_W = $clog2(OFFSET_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(OFFSET_W - 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [OFFSET_W-1:0] q;
  logic [LEN_W-1:0]    rem;
  logic [LEN_W-1:0]    d;

  logic [LEN_W:0]   partial;
  logic             ge;
  logic [LEN_W:0]   diff;

  // shift in next dividend bit, subtract if it fits
  always_comb begin
    partial = {rem, q[OFFSET_W-1]};
    ge      = (partial >= {1'b0, d});
    diff    = partial - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      d   <= divisor;
    end else if (busy) begin
      q   <= {q[OFFSET_W-2:0], ge};
      rem <= ge ? diff[LEN_W-1:0] : partial[LEN_W-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = q;
  assign remainder   = rem;

  `ASSERT_IMP(a_rem_below_divisor, clk, rst, done, (d == '0) || (rem < d))
  `ASSERT_NXT(a_done_single_pulse, clk, rst, done, !done)

endmodule

// ===== rtl/core/object_request_splitter.sv =====
// ----------------------------------------------------------------------------
// object_request_splitter
// Splits a read request (offset, length) into chunks on object boundaries.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  s_axis    in   tdata: byte_offset[47:0], request_length[79:48]
//  m_axis    out  tdata: object_index, chunk_offset, chunk_length,
//                 buffer_position; tuser: status; tlast: last
//  cfg_wr    in   object size (write only)
//
//  Zero-length request: one status transfer, then back to idle.
//  Other requests: the serial divider (48 steps and the done pulse), a check
//  state, then one chunk per cycle while not stalled (up to MAX_CHUNKS);
//  a request over the limit gives one status transfer from the check state.
//  Input is not ready until the last result of a request is in the output
//  register; a stalled output holds the chunk loop.
//  rst is synchronous; object size resets to 4194304 (0 is used as 1).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module object_request_splitter #(
  parameter int unsigned MAX_CHUNKS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [ors_pkg::LEN_W-1:0]         cfg_wr_data,    // object size
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // byte_offset[47:0], request_length[79:48]
  input  logic [ors_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // object_index[47:0], chunk_offset[79:48], chunk_length[111:80],
  // buffer_position[143:112]
  output logic [ors_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status[1:0]
  output logic [ors_pkg::STATUS_W-1:0]      m_axis_tuser,
  output logic                              m_axis_tlast
);
  import ors_pkg::*;

  localparam int CW    = $clog2(MAX_CHUNKS + 1);
  localparam int LIM_W = LEN_W + CW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ZERO  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_CHUNK = 3'd4;

  logic [2:0]          state;
  logic [LEN_W-1:0]    obj_size;
  logic [LEN_W-1:0]    os_eff;

  logic [OFFSET_W-1:0] cur_obj;
  logic [LEN_W-1:0]    remaining;
  logic [LEN_W-1:0]    cur_start;
  logic [LEN_W-1:0]    wpos;
  logic [LIM_W-1:0]    limit;

  logic [OFFSET_W-1:0] in_offset;
  logic [LEN_W-1:0]    in_length;
  logic                in_xfer;
  logic                div_start;
  div_status_t         div_st;
  logic [OFFSET_W-1:0] div_q;
  logic [LEN_W-1:0]    div_r;

  logic                out_free;
  logic                out_load;
  logic [LEN_W-1:0]    room;
  logic                fin;
  logic [LEN_W-1:0]    clen;
  logic [LEN_W:0]      span;
  logic                too_many;

  assign in_offset = s_axis_tdata[OFFSET_W-1:0];
  assign in_length = s_axis_tdata[IN_DATA_W-1:OFFSET_W];
  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign div_start = in_xfer && (in_length != '0);
  assign os_eff    = (obj_size == '0) ? LEN_W'(1) : obj_size;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  ors_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (in_offset),
    .divisor   (os_eff),
    .status    (div_st),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    room     = os_eff - cur_start;
    fin      = (remaining <= room);
    clen     = fin ? remaining : room;
    // bytes from start of first object to last byte, minus one
    span     = {1'b0, remaining} + {1'b0, cur_start} - (LEN_W + 1)'(1);
    too_many = (LIM_W'(span) >= limit);
  end

  // a result is loaded into the output register this cycle
  always_comb begin
    case (state)
      S_ZERO:  out_load = out_free;
      S_CHECK: out_load = out_free && too_many;
      S_CHUNK: out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obj_size <= OBJECT_SIZE_RESET;
    end else if (cfg_wr_en) begin
      obj_size <= cfg_wr_data;
    end
  end

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= (in_length == '0) ? S_ZERO : S_DIV;
          end
        end
        S_ZERO: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!too_many) begin
            state <= S_CHUNK;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_CHUNK: begin
          if (out_free && fin) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // working registers and output payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          remaining <= in_length;
          wpos      <= '0;
          limit     <= LIM_W'(os_eff) * LIM_W'(MAX_CHUNKS);
        end
      end
      S_ZERO: begin
        if (out_free) begin
          m_axis_tdata <= '0;
          m_axis_tuser <= ST_ZERO_LEN;
          m_axis_tlast <= 1'b1;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          cur_obj   <= div_q;
          cur_start <= div_r;
        end
      end
      S_CHECK: begin
        if (too_many && out_free) begin
          m_axis_tdata <= '0;
          m_axis_tuser <= ST_TOO_MANY;
          m_axis_tlast <= 1'b1;
        end
      end
      S_CHUNK: begin
        if (out_free) begin
          m_axis_tdata <= {wpos, clen, cur_start, cur_obj};
          m_axis_tuser <= ST_CHUNK;
          m_axis_tlast <= fin;
          remaining    <= remaining - clen;
          wpos         <= wpos + clen;
          cur_start    <= '0;
          cur_obj      <= cur_obj + OFFSET_W'(1);
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMP(a_status_ends_request, clk, rst,
              m_axis_tvalid && (m_axis_tuser != ST_CHUNK), m_axis_tlast)
  `ASSERT_IMP(a_chunk_has_bytes, clk, rst, state == S_CHUNK, remaining != '0)
  `ASSERT_NXT(a_div_launched, clk, rst, div_start, div_st.busy)

endmodule
